### src/qeav_pkg.sv
package qeav_pkg;

   // Request kinds carried in the mode field.
   localparam logic MODE_PIN  = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Register indexes on the configuration port.
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FULL_RESOLUTION = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_PER_COUNT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATE_PER_COUNT  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_ALPHA    = 2'd3;

   // Register reset values.
   localparam logic        FULL_RESOLUTION_RESET = 1'b1;
   localparam logic [15:0] ALPHA_RESET           = 16'd45875;

   // Fixed widths of the result fields and of the filter arithmetic.
   localparam int unsigned ANGLE_OUT_WIDTH = 48;
   localparam int unsigned SPEED_WIDTH     = 32;
   localparam int unsigned ALPHA_WIDTH     = 16;
   localparam int unsigned SUM_WIDTH       = 50;
   localparam int unsigned MUL_A_WIDTH     = 32;
   localparam int unsigned MUL_B_WIDTH     = 33;
   localparam int unsigned PROD_WIDTH      = MUL_A_WIDTH + MUL_B_WIDTH;

   localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN = 32'sh8000_0000;
   localparam logic [ALPHA_WIDTH:0]          ALPHA_ONE = 17'd65536;
   localparam logic signed [SUM_WIDTH-1:0]   ROUND_HALF = 50'sd32768;

   // Gray code steps between successive pin events.
   localparam logic [1:0] STEP_FORWARD  = 2'd1;
   localparam logic [1:0] STEP_BACKWARD = 2'd3;

   typedef struct packed {
      logic mode;
      logic pin_a;
      logic pin_b;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_OUT_WIDTH-1:0] angle;
      logic signed [SPEED_WIDTH-1:0]     speed;
   } rsp_type;

endpackage

### src/quadrature_encoder_angle_velocity_unit.sv
// Quadrature encoder decoder with angle accumulation and a low-pass speed
// estimate. A pin event request (mode 0) is taken only when idle and
// produces no response. A control tick request (mode 1) produces one
// response carrying the wrapped angle and the filtered speed; it occupies
// the block until its response is registered, as one shared 32 x 33 bit
// signed multiplier is used four times in turn (angle step, raw speed,
// previous-speed weight, new-speed weight) and each product is registered
// before it is consumed. The response waits in an output register, so pin
// events keep being accepted while it is unclaimed; a later tick holds in
// its final step until that register is free. Configuration writes are
// always accepted and must only be issued while the block is idle.
module quadrature_encoder_angle_velocity_unit #(
   parameter int COUNT_WIDTH = 16,
   parameter int ANGLE_WIDTH = 48
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  qeav_pkg::req_type                         req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output qeav_pkg::rsp_type                         rsp_data,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [qeav_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [qeav_pkg::CSR_DATA_WIDTH-1:0]       csr_data
);
   import qeav_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_RAW,
      ST_PREV,
      ST_NEW,
      ST_FINISH,
      ST_EMIT
   } state_type;

   localparam logic signed [COUNT_WIDTH:0] COUNT_MAX = {2'b00, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH:0] COUNT_MIN = {2'b11, {(COUNT_WIDTH-1){1'b0}}};

   state_type                       state_ff, state_in;
   logic                            full_resolution_ff, full_resolution_in;
   logic signed [31:0]              angle_per_count_ff, angle_per_count_in;
   logic signed [31:0]              rate_per_count_ff, rate_per_count_in;
   logic [ALPHA_WIDTH-1:0]          filter_alpha_ff, filter_alpha_in;
   logic signed [COUNT_WIDTH-1:0]   pending_count_ff, pending_count_in;
   logic [1:0]                      last_code_ff, last_code_in;
   logic [ANGLE_WIDTH-1:0]          angle_acc_ff, angle_acc_in;
   logic signed [SPEED_WIDTH-1:0]   speed_est_ff, speed_est_in;
   logic signed [SPEED_WIDTH-1:0]   raw_speed_ff, raw_speed_in;
   logic signed [SUM_WIDTH-1:0]     sum_ff, sum_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   rsp_type                         rsp_data_ff, rsp_data_in;

   logic signed [MUL_A_WIDTH-1:0]   mul_a;
   logic signed [MUL_B_WIDTH-1:0]   mul_b;
   logic signed [PROD_WIDTH-1:0]    prod;

   logic                            req_accept;
   logic                            csr_accept;
   logic [1:0]                      pin_code;
   logic [1:0]                      pin_step;
   logic signed [1:0]               count_delta;
   logic signed [COUNT_WIDTH:0]     count_sum;
   logic signed [COUNT_WIDTH-1:0]   count_sat;
   logic signed [SUM_WIDTH-1:0]     filter_sum;
   logic signed [SUM_WIDTH-1:0]     filter_shift;
   logic signed [SPEED_WIDTH-1:0]   filter_sat;
   logic signed [63:0]              angle_ext;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   // Pin decoding: binary code of the Gray levels, step from the last code.
   assign pin_code = {req_data.pin_a, req_data.pin_a ^ req_data.pin_b};
   assign pin_step = pin_code - last_code_ff;

   always_comb begin
      if (full_resolution_ff) begin
         case (pin_step)
            STEP_FORWARD:  count_delta = 2'sb01;
            STEP_BACKWARD: count_delta = 2'sb11;
            default:       count_delta = 2'sb00;
         endcase
      end else begin
         count_delta = req_data.pin_b ? 2'sb01 : 2'sb11;
      end
   end

   // Saturating update of the pending count.
   assign count_sum = (COUNT_WIDTH+1)'(pending_count_ff) + (COUNT_WIDTH+1)'(count_delta);

   always_comb begin
      if (count_sum > COUNT_MAX) begin
         count_sat = COUNT_MAX[COUNT_WIDTH-1:0];
      end else if (count_sum < COUNT_MIN) begin
         count_sat = COUNT_MIN[COUNT_WIDTH-1:0];
      end else begin
         count_sat = count_sum[COUNT_WIDTH-1:0];
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (state_ff)
         ST_ANGLE: begin
            mul_a = angle_per_count_ff;
            mul_b = MUL_B_WIDTH'(pending_count_ff);
         end
         ST_RAW: begin
            mul_a = rate_per_count_ff;
            mul_b = MUL_B_WIDTH'(pending_count_ff);
         end
         ST_PREV: begin
            mul_a = speed_est_ff;
            mul_b = $signed({{(MUL_B_WIDTH-ALPHA_WIDTH){1'b0}}, filter_alpha_ff});
         end
         ST_NEW: begin
            mul_a = raw_speed_ff;
            mul_b = $signed({{(MUL_B_WIDTH-ALPHA_WIDTH-1){1'b0}},
                             ALPHA_ONE - {1'b0, filter_alpha_ff}});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   qeav_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // Filter: weighted sum, round half up, floor shift and saturate.
   assign filter_sum   = sum_ff + $signed(prod[SUM_WIDTH-1:0]) + ROUND_HALF;
   assign filter_shift = filter_sum >>> ALPHA_WIDTH;

   always_comb begin
      if (filter_shift > SUM_WIDTH'(SPEED_MAX)) begin
         filter_sat = SPEED_MAX;
      end else if (filter_shift < SUM_WIDTH'(SPEED_MIN)) begin
         filter_sat = SPEED_MIN;
      end else begin
         filter_sat = filter_shift[SPEED_WIDTH-1:0];
      end
   end

   assign angle_ext = 64'(signed'(angle_acc_ff));

   // Sequencer and next values of all registers.
   always_comb begin
      state_in           = state_ff;
      full_resolution_in = full_resolution_ff;
      angle_per_count_in = angle_per_count_ff;
      rate_per_count_in  = rate_per_count_ff;
      filter_alpha_in    = filter_alpha_ff;
      pending_count_in   = pending_count_ff;
      last_code_in       = last_code_ff;
      angle_acc_in       = angle_acc_ff;
      speed_est_in       = speed_est_ff;
      raw_speed_in       = raw_speed_ff;
      sum_in             = sum_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_data_in        = rsp_data_ff;

      if (csr_accept) begin
         case (csr_index)
            CSR_FULL_RESOLUTION: full_resolution_in = csr_data[0];
            CSR_ANGLE_PER_COUNT: angle_per_count_in = csr_data;
            CSR_RATE_PER_COUNT:  rate_per_count_in  = csr_data;
            CSR_FILTER_ALPHA:    filter_alpha_in    = csr_data[ALPHA_WIDTH-1:0];
            default:             ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.mode == MODE_TICK) begin
                  state_in = ST_ANGLE;
               end else begin
                  pending_count_in = count_sat;
                  if (full_resolution_ff) begin
                     last_code_in = pin_code;
                  end
               end
            end
         end
         ST_ANGLE: begin
            state_in = ST_RAW;
         end
         ST_RAW: begin
            // Angle step product is ready.
            angle_acc_in = angle_acc_ff + prod[ANGLE_WIDTH-1:0];
            state_in     = ST_PREV;
         end
         ST_PREV: begin
            // Raw speed product is ready; clamp it to 32 bits.
            if (prod > PROD_WIDTH'(SPEED_MAX)) begin
               raw_speed_in = SPEED_MAX;
            end else if (prod < PROD_WIDTH'(SPEED_MIN)) begin
               raw_speed_in = SPEED_MIN;
            end else begin
               raw_speed_in = prod[SPEED_WIDTH-1:0];
            end
            state_in = ST_NEW;
         end
         ST_NEW: begin
            sum_in   = prod[SUM_WIDTH-1:0];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            speed_est_in     = filter_sat;
            pending_count_in = '0;
            state_in         = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.angle  = angle_ext[ANGLE_OUT_WIDTH-1:0];
               rsp_data_in.speed  = speed_est_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         full_resolution_ff <= FULL_RESOLUTION_RESET;
         angle_per_count_ff <= '0;
         rate_per_count_ff  <= '0;
         filter_alpha_ff    <= ALPHA_RESET;
         pending_count_ff   <= '0;
         last_code_ff       <= '0;
         angle_acc_ff       <= '0;
         speed_est_ff       <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         full_resolution_ff <= full_resolution_in;
         angle_per_count_ff <= angle_per_count_in;
         rate_per_count_ff  <= rate_per_count_in;
         filter_alpha_ff    <= filter_alpha_in;
         pending_count_ff   <= pending_count_in;
         last_code_ff       <= last_code_in;
         angle_acc_ff       <= angle_acc_in;
         speed_est_ff       <= speed_est_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      raw_speed_ff <= raw_speed_in;
      sum_ff       <= sum_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A tick request starts the multiply sequence on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.mode == MODE_TICK) |=> state_ff == ST_ANGLE)
      else $error("tick request did not start the multiply sequence");

   // A pin event never disturbs the angle or the speed estimate.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.mode == MODE_PIN) |=>
         $stable(angle_acc_ff) && $stable(speed_est_ff))
      else $error("pin event changed angle or speed");

   // Single mode pin events leave the last pin code alone.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.mode == MODE_PIN) && !full_resolution_ff |=>
         $stable(last_code_ff))
      else $error("single mode pin event moved the last code");

   // The pending count is cleared before a response is issued.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (pending_count_ff == '0))
      else $error("pending count not cleared at response time");

endmodule

### src/qeav_mul.sv
module qeav_mul (
   input  logic                                clock,
   input  logic signed [qeav_pkg::MUL_A_WIDTH-1:0] op_a,
   input  logic signed [qeav_pkg::MUL_B_WIDTH-1:0] op_b,
   output logic signed [qeav_pkg::PROD_WIDTH-1:0]  prod
);
   import qeav_pkg::*;

   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [PROD_WIDTH-1:0] prod_in;

   // Full signed product, registered before any use.
   assign prod_in = PROD_WIDTH'(op_a) * PROD_WIDTH'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
